// File: src/icdc_pkg.sv
// shared types, widths and constants of the incubator climate and day controller
package icdc_pkg;

   localparam int TEMP_W   = 10;
   localparam int HUM_W    = 10;
   localparam int DAYS_W   = 6;
   localparam int DAY_W    = 8;
   localparam int PERIOD_W = 4;
   localparam int MIN_W    = 6;
   localparam int SEC_W    = 6;
   localparam int TURN_W   = 3;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int PERIODS_PER_DAY_DEF = 12;
   localparam int TURN_SECONDS_DEF    = 5;

   // fixed temperature thresholds in tenths of a degree
   localparam logic [TEMP_W-1:0] T_ALARM   = 10'd372;
   localparam logic [TEMP_W-1:0] T_EXACT   = 10'd375;
   localparam logic [TEMP_W-1:0] T_CUT     = 10'd382;
   localparam logic [TEMP_W-1:0] T_EXHAUST = 10'd388;

   // countdown reload values
   localparam logic [SEC_W-1:0]    SEC_RELOAD  = 6'd59;
   localparam logic [MIN_W-1:0]    MIN_RELOAD  = 6'd59;
   localparam logic                HOUR_RELOAD = 1'b1;
   localparam logic [DAY_W-1:0]    DAY_FIRST   = 8'd1;
   localparam logic [PERIOD_W-1:0] PERIOD_FIRST = 4'd0;

   // register reset values
   localparam logic [TEMP_W-1:0] TEMP_LOW_RST  = 10'd374;
   localparam logic [TEMP_W-1:0] TEMP_HIGH_RST = 10'd384;
   localparam logic [HUM_W-1:0]  HUM_LO_INC_RST = 10'd450;
   localparam logic [HUM_W-1:0]  HUM_HI_INC_RST = 10'd550;
   localparam logic [HUM_W-1:0]  HUM_LO_HAT_RST = 10'd700;
   localparam logic [HUM_W-1:0]  HUM_HI_HAT_RST = 10'd750;
   localparam logic [DAYS_W-1:0] INC_DAYS_RST   = 6'd18;
   localparam logic [DAYS_W-1:0] HAT_DAYS_RST   = 6'd3;

   typedef enum logic [2:0] {
      REG_TEMP_LOW   = 3'd0,
      REG_TEMP_HIGH  = 3'd1,
      REG_HUM_LO_INC = 3'd2,
      REG_HUM_HI_INC = 3'd3,
      REG_HUM_LO_HAT = 3'd4,
      REG_HUM_HI_HAT = 3'd5,
      REG_INC_DAYS   = 3'd6,
      REG_HAT_DAYS   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [TEMP_W-1:0] temp_low_limit;
      logic [TEMP_W-1:0] temp_high_limit;
      logic [HUM_W-1:0]  hum_low_incubating;
      logic [HUM_W-1:0]  hum_high_incubating;
      logic [HUM_W-1:0]  hum_low_hatching;
      logic [HUM_W-1:0]  hum_high_hatching;
      logic [DAYS_W-1:0] incubating_days;
      logic [DAYS_W-1:0] hatching_days;
   } cfg_type;

   typedef struct packed {
      logic                turner_on;
      logic [DAY_W-1:0]    day;
      logic [PERIOD_W-1:0] period;
      logic                hours;
      logic [MIN_W-1:0]    minutes;
      logic [SEC_W-1:0]    seconds;
   } clock_status_type;

   typedef struct packed {
      logic heater_on;
      logic humidifier_on;
      logic circulation_fan_on;
      logic exhaust_fan_on;
      logic alarm_on;
   } climate_status_type;

endpackage

// File: src/icdc_req_if.sv
// sample channel carrying one control sample per transfer
interface icdc_req_if;
   logic                              valid;
   logic                              ready;
   logic [icdc_pkg::TEMP_W-1:0]       temperature;
   logic [icdc_pkg::HUM_W-1:0]        humidity;
   logic                              mains_present;
   logic                              second_tick;
   logic                              run;
   logic                              restart;

   modport source (
      output valid, temperature, humidity, mains_present, second_tick, run, restart,
      input  ready
   );
   modport sink (
      input  valid, temperature, humidity, mains_present, second_tick, run, restart,
      output ready
   );
endinterface

// File: src/icdc_rsp_if.sv
// result channel carrying drive levels and clock status per transfer
interface icdc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              heater_on;
   logic                              humidifier_on;
   logic                              circulation_fan_on;
   logic                              exhaust_fan_on;
   logic                              alarm_on;
   logic                              turner_on;
   logic                              on_gas;
   logic [icdc_pkg::DAY_W-1:0]        day_number;
   logic [icdc_pkg::PERIOD_W-1:0]     period_of_day;
   logic                              hours_left;
   logic [icdc_pkg::MIN_W-1:0]        minutes_left;
   logic [icdc_pkg::SEC_W-1:0]        seconds_left;

   modport source (
      output valid, heater_on, humidifier_on, circulation_fan_on, exhaust_fan_on,
             alarm_on, turner_on, on_gas, day_number, period_of_day, hours_left,
             minutes_left, seconds_left,
      input  ready
   );
   modport sink (
      input  valid, heater_on, humidifier_on, circulation_fan_on, exhaust_fan_on,
             alarm_on, turner_on, on_gas, day_number, period_of_day, hours_left,
             minutes_left, seconds_left,
      output ready
   );
endinterface

// File: src/icdc_csr.sv
// configuration register file behind the apb-style port
module icdc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [icdc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [icdc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [icdc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output icdc_pkg::cfg_type                 cfg
);

   icdc_pkg::cfg_type       cfg_ff;
   icdc_pkg::cfg_type       cfg_in;
   icdc_pkg::reg_index_type reg_sel;
   logic                    wr_en;

   assign reg_sel = icdc_pkg::reg_index_type'(paddr[icdc_pkg::CSR_ADDR_W-1:2]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            icdc_pkg::REG_TEMP_LOW:   cfg_in.temp_low_limit      = pwdata[icdc_pkg::TEMP_W-1:0];
            icdc_pkg::REG_TEMP_HIGH:  cfg_in.temp_high_limit     = pwdata[icdc_pkg::TEMP_W-1:0];
            icdc_pkg::REG_HUM_LO_INC: cfg_in.hum_low_incubating  = pwdata[icdc_pkg::HUM_W-1:0];
            icdc_pkg::REG_HUM_HI_INC: cfg_in.hum_high_incubating = pwdata[icdc_pkg::HUM_W-1:0];
            icdc_pkg::REG_HUM_LO_HAT: cfg_in.hum_low_hatching    = pwdata[icdc_pkg::HUM_W-1:0];
            icdc_pkg::REG_HUM_HI_HAT: cfg_in.hum_high_hatching   = pwdata[icdc_pkg::HUM_W-1:0];
            icdc_pkg::REG_INC_DAYS:   cfg_in.incubating_days     = pwdata[icdc_pkg::DAYS_W-1:0];
            icdc_pkg::REG_HAT_DAYS:   cfg_in.hatching_days       = pwdata[icdc_pkg::DAYS_W-1:0];
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_sel)
         icdc_pkg::REG_TEMP_LOW:   prdata[icdc_pkg::TEMP_W-1:0] = cfg_ff.temp_low_limit;
         icdc_pkg::REG_TEMP_HIGH:  prdata[icdc_pkg::TEMP_W-1:0] = cfg_ff.temp_high_limit;
         icdc_pkg::REG_HUM_LO_INC: prdata[icdc_pkg::HUM_W-1:0]  = cfg_ff.hum_low_incubating;
         icdc_pkg::REG_HUM_HI_INC: prdata[icdc_pkg::HUM_W-1:0]  = cfg_ff.hum_high_incubating;
         icdc_pkg::REG_HUM_LO_HAT: prdata[icdc_pkg::HUM_W-1:0]  = cfg_ff.hum_low_hatching;
         icdc_pkg::REG_HUM_HI_HAT: prdata[icdc_pkg::HUM_W-1:0]  = cfg_ff.hum_high_hatching;
         icdc_pkg::REG_INC_DAYS:   prdata[icdc_pkg::DAYS_W-1:0] = cfg_ff.incubating_days;
         icdc_pkg::REG_HAT_DAYS:   prdata[icdc_pkg::DAYS_W-1:0] = cfg_ff.hatching_days;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_low_limit      <= icdc_pkg::TEMP_LOW_RST;
         cfg_ff.temp_high_limit     <= icdc_pkg::TEMP_HIGH_RST;
         cfg_ff.hum_low_incubating  <= icdc_pkg::HUM_LO_INC_RST;
         cfg_ff.hum_high_incubating <= icdc_pkg::HUM_HI_INC_RST;
         cfg_ff.hum_low_hatching    <= icdc_pkg::HUM_LO_HAT_RST;
         cfg_ff.hum_high_hatching   <= icdc_pkg::HUM_HI_HAT_RST;
         cfg_ff.incubating_days     <= icdc_pkg::INC_DAYS_RST;
         cfg_ff.hatching_days       <= icdc_pkg::HAT_DAYS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: src/icdc_clock.sv
// countdown clock, day counter and egg turner timing
module icdc_clock #(
   parameter int PERIODS_PER_DAY = icdc_pkg::PERIODS_PER_DAY_DEF,
   parameter int TURN_SECONDS    = icdc_pkg::TURN_SECONDS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             tick,
   input  logic                             restart,
   input  logic [icdc_pkg::DAYS_W-1:0]      incubating_days,
   input  logic [icdc_pkg::DAYS_W-1:0]      hatching_days,
   output icdc_pkg::clock_status_type       status_next
);

   localparam logic [icdc_pkg::PERIOD_W-1:0] PERIOD_LAST =
      icdc_pkg::PERIOD_W'(PERIODS_PER_DAY - 1);
   localparam logic [icdc_pkg::TURN_W-1:0] TURN_LAST = icdc_pkg::TURN_W'(TURN_SECONDS);

   logic                              turner_ff, turner_in;
   logic [icdc_pkg::TURN_W-1:0]       turn_sec_ff, turn_sec_in;
   logic [icdc_pkg::SEC_W-1:0]        sec_ff, sec_in;
   logic [icdc_pkg::MIN_W-1:0]        min_ff, min_in;
   logic                              hour_ff, hour_in;
   logic [icdc_pkg::PERIOD_W-1:0]     period_ff, period_in;
   logic [icdc_pkg::DAY_W-1:0]        day_ff, day_in;
   logic [icdc_pkg::TURN_W-1:0]       turn_sec_inc;
   logic [icdc_pkg::PERIOD_W-1:0]     period_inc;
   logic [icdc_pkg::DAY_W-1:0]        day_inc;
   logic [icdc_pkg::DAY_W-1:0]        day_limit;
   logic                              boundary;

   assign turn_sec_inc = turn_sec_ff + 1'b1;
   assign period_inc   = period_ff + 1'b1;
   assign day_inc      = day_ff + 1'b1;
   assign day_limit    = icdc_pkg::DAY_W'(incubating_days) + icdc_pkg::DAY_W'(hatching_days)
                         + icdc_pkg::DAY_W'(2);

   always_comb begin
      turner_in   = turner_ff;
      turn_sec_in = turn_sec_ff;
      sec_in      = sec_ff;
      min_in      = min_ff;
      hour_in     = hour_ff;
      period_in   = period_ff;
      day_in      = day_ff;
      boundary    = 1'b0;

      // running turner counts its seconds and stops after the turn time
      if (tick && turner_ff) begin
         if (turn_sec_inc >= TURN_LAST) begin
            turner_in   = 1'b0;
            turn_sec_in = '0;
         end else begin
            turn_sec_in = turn_sec_inc;
         end
      end

      if (restart) begin
         sec_in    = icdc_pkg::SEC_RELOAD;
         min_in    = icdc_pkg::MIN_RELOAD;
         hour_in   = icdc_pkg::HOUR_RELOAD;
         period_in = icdc_pkg::PERIOD_FIRST;
         day_in    = icdc_pkg::DAY_FIRST;
      end else if (tick) begin
         if (sec_ff != '0) begin
            sec_in = sec_ff - 1'b1;
         end else begin
            sec_in = icdc_pkg::SEC_RELOAD;
            if (min_ff != '0) begin
               min_in = min_ff - 1'b1;
            end else begin
               min_in = icdc_pkg::MIN_RELOAD;
               if (hour_ff) begin
                  hour_in = 1'b0;
               end else begin
                  hour_in  = icdc_pkg::HOUR_RELOAD;
                  boundary = 1'b1;
                  if (period_inc > PERIOD_LAST) begin
                     period_in = '0;
                     day_in    = (day_inc > day_limit) ? icdc_pkg::DAY_FIRST : day_inc;
                  end else begin
                     period_in = period_inc;
                  end
               end
            end
         end
         if (boundary && (day_ff < icdc_pkg::DAY_W'(incubating_days))) begin
            turner_in   = 1'b1;
            turn_sec_in = '0;
         end
      end
   end

   assign status_next = '{turner_on: turner_in, day: day_in, period: period_in,
                          hours: hour_in, minutes: min_in, seconds: sec_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         turner_ff   <= 1'b0;
         turn_sec_ff <= '0;
         sec_ff      <= icdc_pkg::SEC_RELOAD;
         min_ff      <= icdc_pkg::MIN_RELOAD;
         hour_ff     <= icdc_pkg::HOUR_RELOAD;
         period_ff   <= icdc_pkg::PERIOD_FIRST;
         day_ff      <= icdc_pkg::DAY_FIRST;
      end else if (advance) begin
         turner_ff   <= turner_in;
         turn_sec_ff <= turn_sec_in;
         sec_ff      <= sec_in;
         min_ff      <= min_in;
         hour_ff     <= hour_in;
         period_ff   <= period_in;
         day_ff      <= day_in;
      end
   end

   a_restart_loads: assert property (@(posedge clock) disable iff (reset)
      advance && restart |=> day_ff == icdc_pkg::DAY_FIRST &&
                             period_ff == icdc_pkg::PERIOD_FIRST &&
                             sec_ff == icdc_pkg::SEC_RELOAD)
      else $error("restart did not reload the clock");

   a_no_tick_holds: assert property (@(posedge clock) disable iff (reset)
      advance && !restart && !tick |=>
         $stable({day_ff, period_ff, hour_ff, min_ff, sec_ff}))
      else $error("clock moved without a tick");

   a_turner_count: assert property (@(posedge clock) disable iff (reset)
      turner_ff |-> turn_sec_ff < TURN_LAST)
      else $error("turner ran past its turn time");

endmodule

// File: src/icdc_climate.sv
// heater, humidifier, fans and low-temperature alarm levels
module icdc_climate (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic [icdc_pkg::TEMP_W-1:0]      temperature,
   input  logic [icdc_pkg::HUM_W-1:0]       humidity,
   input  logic                             mains_present,
   input  logic                             tick,
   input  logic                             run,
   input  logic [icdc_pkg::DAY_W-1:0]       day_next,
   input  icdc_pkg::cfg_type                cfg,
   output icdc_pkg::climate_status_type     status_next
);

   logic heater_ff, heater_in;
   logic humid_ff, humid_in;
   logic fan_ff, fan_in;
   logic exhaust_ff, exhaust_in;
   logic alarm_ff, alarm_in;
   logic blink_ff, blink_in;
   logic [icdc_pkg::HUM_W-1:0] hum_lo, hum_hi;
   logic cold;

   assign cold = temperature <= cfg.temp_low_limit;

   always_comb begin
      if (day_next <= icdc_pkg::DAY_W'(cfg.incubating_days)) begin
         hum_lo = cfg.hum_low_incubating;
         hum_hi = cfg.hum_high_incubating;
      end else begin
         hum_lo = cfg.hum_low_hatching;
         hum_hi = cfg.hum_high_hatching;
      end
   end

   always_comb begin
      heater_in  = heater_ff;
      humid_in   = humid_ff;
      exhaust_in = exhaust_ff;
      alarm_in   = alarm_ff;
      blink_in   = blink_ff;
      fan_in     = run;
      if (run) begin
         // later checks win over earlier ones
         if (cold && mains_present) heater_in = 1'b1;
         if ((temperature == icdc_pkg::T_EXACT) && mains_present) heater_in = 1'b1;
         if ((temperature >= icdc_pkg::T_CUT) && mains_present) heater_in = 1'b0;
         if (temperature >= cfg.temp_high_limit) heater_in = 1'b0;
         alarm_in = cold ? blink_ff : 1'b0;
         if (tick) blink_in = (temperature < icdc_pkg::T_ALARM) ? ~blink_ff : 1'b0;
         exhaust_in = temperature > icdc_pkg::T_EXHAUST;
         if (humidity < hum_lo) humid_in = 1'b1;
         if (humidity >= hum_hi) humid_in = 1'b0;
      end else begin
         heater_in = 1'b0;
      end
   end

   assign status_next = '{heater_on: heater_in, humidifier_on: humid_in,
                          circulation_fan_on: fan_in, exhaust_fan_on: exhaust_in,
                          alarm_on: alarm_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         heater_ff  <= 1'b0;
         humid_ff   <= 1'b0;
         fan_ff     <= 1'b0;
         exhaust_ff <= 1'b0;
         alarm_ff   <= 1'b0;
         blink_ff   <= 1'b0;
      end else if (advance) begin
         heater_ff  <= heater_in;
         humid_ff   <= humid_in;
         fan_ff     <= fan_in;
         exhaust_ff <= exhaust_in;
         alarm_ff   <= alarm_in;
         blink_ff   <= blink_in;
      end
   end

   a_idle_heater_off: assert property (@(posedge clock) disable iff (reset)
      advance && !run |=> !heater_ff && !fan_ff)
      else $error("heater or fan left on while not running");

endmodule

// File: src/incubator_climate_and_day_control.sv
// top level of the incubator climate and day controller
// Takes one control sample per transfer and returns one result per sample.
// A sample is captured in an input register, and all climate and clock updates
// are worked out in one short combinational pass into the result register, so
// a new sample is taken every cycle unless the result side stalls; its result
// is offered from the result register. The result register and the input
// register let a new sample enter while a finished result still waits; only
// when both are full and the result side stalls does the sample side stall.
// The clock (seconds, minutes, two-hour periods, days) and the egg turner
// move on samples that carry a second tick. Limits and phase lengths are
// written through the apb-style port at byte address 4 * index; the user
// must write them only while no sample is in flight, which the block does
// not enforce. There is no clearing pass after reset.
module incubator_climate_and_day_control #(
   parameter int PERIODS_PER_DAY = icdc_pkg::PERIODS_PER_DAY_DEF,
   parameter int TURN_SECONDS    = icdc_pkg::TURN_SECONDS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   icdc_req_if.sink                          req_bus,
   icdc_rsp_if.source                        rsp_bus,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [icdc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [icdc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [icdc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   icdc_pkg::cfg_type             cfg;
   icdc_pkg::clock_status_type    clk_next;
   icdc_pkg::climate_status_type  clim_next;

   // input register
   logic                          smp_valid_ff, smp_valid_in;
   logic [icdc_pkg::TEMP_W-1:0]   smp_temp_ff;
   logic [icdc_pkg::HUM_W-1:0]    smp_hum_ff;
   logic                          smp_mains_ff;
   logic                          smp_tick_ff;
   logic                          smp_run_ff;
   logic                          smp_restart_ff;

   // result register
   logic                          res_valid_ff, res_valid_in;
   icdc_pkg::clock_status_type    res_clk_ff;
   icdc_pkg::climate_status_type  res_clim_ff;
   logic                          res_gas_ff;

   logic req_take;
   logic advance;

   // the held sample moves on when the result register is free or being emptied
   assign advance      = smp_valid_ff & (~res_valid_ff | rsp_bus.ready);
   assign req_bus.ready = ~smp_valid_ff | advance;
   assign req_take     = req_bus.valid & req_bus.ready;

   assign smp_valid_in = req_take | (smp_valid_ff & ~advance);
   assign res_valid_in = advance | (res_valid_ff & ~rsp_bus.ready);

   icdc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   icdc_clock #(
      .PERIODS_PER_DAY (PERIODS_PER_DAY),
      .TURN_SECONDS    (TURN_SECONDS)
   ) u_clock (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .tick            (smp_tick_ff),
      .restart         (smp_restart_ff),
      .incubating_days (cfg.incubating_days),
      .hatching_days   (cfg.hatching_days),
      .status_next     (clk_next)
   );

   // humidity phase follows the day as it stands after this sample's tick
   icdc_climate u_climate (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .temperature   (smp_temp_ff),
      .humidity      (smp_hum_ff),
      .mains_present (smp_mains_ff),
      .tick          (smp_tick_ff),
      .run           (smp_run_ff),
      .day_next      (clk_next.day),
      .cfg           (cfg),
      .status_next   (clim_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         smp_valid_ff <= smp_valid_in;
         res_valid_ff <= res_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         smp_temp_ff    <= req_bus.temperature;
         smp_hum_ff     <= req_bus.humidity;
         smp_mains_ff   <= req_bus.mains_present;
         smp_tick_ff    <= req_bus.second_tick;
         smp_run_ff     <= req_bus.run;
         smp_restart_ff <= req_bus.restart;
      end
      if (advance) begin
         res_clk_ff  <= clk_next;
         res_clim_ff <= clim_next;
         res_gas_ff  <= ~smp_mains_ff;
      end
   end

   assign rsp_bus.valid              = res_valid_ff;
   assign rsp_bus.heater_on          = res_clim_ff.heater_on;
   assign rsp_bus.humidifier_on      = res_clim_ff.humidifier_on;
   assign rsp_bus.circulation_fan_on = res_clim_ff.circulation_fan_on;
   assign rsp_bus.exhaust_fan_on     = res_clim_ff.exhaust_fan_on;
   assign rsp_bus.alarm_on           = res_clim_ff.alarm_on;
   assign rsp_bus.turner_on          = res_clk_ff.turner_on;
   assign rsp_bus.on_gas             = res_gas_ff;
   assign rsp_bus.day_number         = res_clk_ff.day;
   assign rsp_bus.period_of_day      = res_clk_ff.period;
   assign rsp_bus.hours_left         = res_clk_ff.hours;
   assign rsp_bus.minutes_left       = res_clk_ff.minutes;
   assign rsp_bus.seconds_left       = res_clk_ff.seconds;

   a_advance_fills_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> res_valid_ff)
      else $error("result register not loaded after a sample moved on");

   a_no_lost_sample: assert property (@(posedge clock) disable iff (reset)
      smp_valid_ff && !advance |=> smp_valid_ff && $stable(smp_temp_ff))
      else $error("held sample dropped or changed before it moved on");

endmodule
